### rtl/sliding_median_with_bypass_defines.svh
// assertion macros for the sliding median block
`ifndef SLIDING_MEDIAN_WITH_BYPASS_DEFINES_SVH
`define SLIDING_MEDIAN_WITH_BYPASS_DEFINES_SVH

`ifndef ASSERT_OFF

`define SMBP_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("smbp assertion failed");

`define SMBP_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("smbp assertion failed");

`else

`define SMBP_ASSERT(lbl, clk_s, rst_s, prop)

`define SMBP_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

### rtl/smbp_pkg.sv
`timescale 1ns / 1ps

package smbp_pkg;

  localparam int WINDOW   = 20;
  localparam int SAMPLE_W = 16;
  localparam int HALF_W   = 17;
  localparam int CNT_W    = 5;
  localparam int AGE_W    = $clog2(WINDOW);
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int THR_W    = 16;

  localparam logic [CNT_W-1:0]  HIST_DEPTH      = CNT_W'(WINDOW - 1);
  localparam logic [AGE_W-1:0]  AGE_LAST        = AGE_W'(WINDOW - 1);
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd16384;
  localparam logic [ADDR_W-3:0] REG_THRESHOLD   = '0;

  typedef struct packed {
    logic [SAMPLE_W-1:0] val;
    logic [AGE_W-1:0]    age;
  } slot_t;

  typedef struct packed {
    logic rank_en;
    logic shift_en;
    logic drop;
  } cell_ctrl_t;

endpackage

### rtl/smbp_cell.sv
`timescale 1ns / 1ps

module smbp_cell
  import smbp_pkg::*;
(
  input  logic                       clk,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic signed [SAMPLE_W-1:0] old_val,
  input  logic                       occ,
  input  logic                       lt_prev,
  input  slot_t                      prev_slot,
  input  slot_t                      next_win,
  output logic                       lt,
  output slot_t                      store,
  output slot_t                      win
);

  slot_t win_next;
  logic  gone;

  assign lt = occ && ($signed(store.val) < sample);

  always_comb begin
    if (lt) begin
      win_next.val = store.val;
      win_next.age = store.age + AGE_W'(1);
    end else if (lt_prev) begin
      win_next.val = sample;
      win_next.age = '0;
    end else begin
      win_next.val = prev_slot.val;
      win_next.age = prev_slot.age + AGE_W'(1);
    end
  end

  // window is ordered by value then age, so the dropped slot splits it in two
  assign gone = ctrl.drop && (($signed(win.val) > old_val) ||
                              (($signed(win.val) == old_val) && (win.age == AGE_LAST)));

  always_ff @(posedge clk) begin
    if (ctrl.rank_en) begin
      win <= win_next;
    end
    if (ctrl.shift_en) begin
      store <= gone ? next_win : win;
    end
  end

endmodule

### rtl/sliding_median_with_bypass.sv
`timescale 1ns / 1ps
// channel  | handshake            | payload
// in       | in_valid / in_ready  | sample
// out      | out_valid / out_ready| filtered_half, bypassed, fill_count
// config   | psel/penable/pwrite  | paddr, pwdata, prdata (bypass_threshold)
//
// each item steps through capture, rank against the sorted cell row, median select
// with row shift, then threshold compare into the output register.
// the output register frees the input side: a new item is taken while a result waits.
// the compare step holds while the output register is still full.
// reset clears the fill count and output valid and sets the threshold to 16384.

`include "sliding_median_with_bypass_defines.svh"

module sliding_median_with_bypass
  import smbp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [HALF_W-1:0]   filtered_half,
  output logic                       bypassed,
  output logic [CNT_W-1:0]           fill_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  typedef enum logic [1:0] {S_IDLE, S_RANK, S_MED, S_OUT} state_t;

  state_t                     state;
  logic [CNT_W-1:0]           fill;
  logic [CNT_W-1:0]           fill_next;
  logic [CNT_W-1:0]           n_reg;
  logic signed [SAMPLE_W-1:0] sample_reg;
  logic signed [SAMPLE_W-1:0] old_val;
  logic signed [SAMPLE_W-1:0] old_val_next;
  logic signed [HALF_W-1:0]   med_half;
  logic signed [HALF_W-1:0]   med_next;
  logic [THR_W-1:0]           threshold;

  cell_ctrl_t                 ctrl;
  slot_t                      store_s [WINDOW];
  slot_t                      win_s   [WINDOW];
  logic [WINDOW-1:0]          lt_v;
  logic [WINDOW-1:0]          occ_v;

  logic [CNT_W-1:0]           lo_idx;
  logic [CNT_W-1:0]           hi_idx;
  logic [SAMPLE_W-1:0]        lo_val;
  logic [SAMPLE_W-1:0]        hi_val;
  logic signed [HALF_W:0]     diff;
  logic [HALF_W:0]            mag;
  logic                       hit;
  logic                       cfg_wr;

  assign in_ready = (state == S_IDLE);

  assign ctrl.rank_en  = (state == S_RANK);
  assign ctrl.shift_en = (state == S_MED);
  assign ctrl.drop     = (fill == HIST_DEPTH);

  genvar i;
  generate
    for (i = 0; i < WINDOW; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      assign occ_v[i] = (IDX < fill);
      if (i == 0) begin : g_first
        smbp_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .sample    (sample_reg),
          .old_val   (old_val),
          .occ       (occ_v[i]),
          .lt_prev   (1'b1),
          .prev_slot ('0),
          .next_win  (win_s[i+1]),
          .lt        (lt_v[i]),
          .store     (store_s[i]),
          .win       (win_s[i])
        );
      end else if (i == WINDOW - 1) begin : g_last
        smbp_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .sample    (sample_reg),
          .old_val   (old_val),
          .occ       (occ_v[i]),
          .lt_prev   (lt_v[i-1]),
          .prev_slot (store_s[i-1]),
          .next_win  ('0),
          .lt        (lt_v[i]),
          .store     (store_s[i]),
          .win       (win_s[i])
        );
      end else begin : g_mid
        smbp_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .sample    (sample_reg),
          .old_val   (old_val),
          .occ       (occ_v[i]),
          .lt_prev   (lt_v[i-1]),
          .prev_slot (store_s[i-1]),
          .next_win  (win_s[i+1]),
          .lt        (lt_v[i]),
          .store     (store_s[i]),
          .win       (win_s[i])
        );
      end
    end
  endgenerate

  // oldest kept sample
  always_comb begin
    old_val_next = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (occ_v[k] && (CNT_W'(store_s[k].age) == fill - CNT_W'(1))) begin
        old_val_next = old_val_next | $signed(store_s[k].val);
      end
    end
  end

  // middle slots of the window
  assign lo_idx = fill >> 1;
  assign hi_idx = (fill + CNT_W'(1)) >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (CNT_W'(k) == lo_idx) begin
        lo_val = lo_val | win_s[k].val;
      end
      if (CNT_W'(k) == hi_idx) begin
        hi_val = hi_val | win_s[k].val;
      end
    end
  end

  assign med_next  = HALF_W'($signed(lo_val)) + HALF_W'($signed(hi_val));
  assign fill_next = (fill == HIST_DEPTH) ? HIST_DEPTH : fill + CNT_W'(1);

  assign diff = $signed({sample_reg[SAMPLE_W-1], sample_reg, 1'b0})
              - $signed({med_half[HALF_W-1], med_half});
  assign mag  = diff[HALF_W] ? (HALF_W+1)'(-diff) : (HALF_W+1)'(diff);
  assign hit  = (mag > {1'b0, threshold, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_reg <= sample;
            state      <= S_RANK;
          end
        end
        S_RANK: begin
          old_val <= old_val_next;
          state   <= S_MED;
        end
        S_MED: begin
          med_half <= med_next;
          n_reg    <= fill + CNT_W'(1);
          fill     <= fill_next;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            filtered_half <= hit ? $signed({sample_reg, 1'b0}) : med_half;
            bypassed      <= hit;
            fill_count    <= n_reg;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[ADDR_W-1:2] == REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_THRESHOLD) ? DATA_W'(threshold) : '0;

  `SMBP_ASSERT(a_fill_bound, clk, rst, fill <= HIST_DEPTH)
  `SMBP_ASSERT(a_row_sorted, clk, rst, (lt_v & (lt_v + WINDOW'(1))) == '0)
  `SMBP_ASSERT(a_fill_step, clk, rst, (state == S_MED) |=> ((fill == $past(fill) + CNT_W'(1)) || ((fill == HIST_DEPTH) && ($past(fill) == HIST_DEPTH))))
  `SMBP_ASSERT_ALWAYS(a_rst_idle, clk, $past(rst) |-> (!out_valid && in_ready))

endmodule

### tb/sliding_median_with_bypass_test.sv
`timescale 1ns / 1ps

module sliding_median_with_bypass_test;
  import smbp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 267;
  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);

  typedef struct packed {
    logic signed [HALF_W-1:0] filtered_half;
    logic                     bypassed;
    logic [CNT_W-1:0]         fill_count;
  } filter_out_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [HALF_W-1:0]   filtered_half;
  logic                       bypassed;
  logic [CNT_W-1:0]           fill_count;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  sliding_median_with_bypass dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .filtered_half(filtered_half), .bypassed(bypassed), .fill_count(fill_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // model state
  logic signed [SAMPLE_W-1:0] history [WINDOW-1];
  int                         history_fill = 0;
  logic [THR_W-1:0]           threshold_now = THRESHOLD_RESET;

  logic signed [SAMPLE_W-1:0] samples_to_send [$];
  filter_out_t                due_results [$];
  logic signed [SAMPLE_W-1:0] walk_base = '0;
  bit                         in_taken = 1'b0;
  int                         send_idle = 0;
  int                         recv_idle = 0;
  int                         errors = 0;
  int                         cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic filter_out_t predict_median(input logic signed [SAMPLE_W-1:0] s);
    int win [WINDOW];
    int n, i, j, v, med_half, gap, keep, sv;
    filter_out_t r;
    sv = s;
    n = history_fill + 1;
    win[0] = sv;
    for (i = 0; i < history_fill; i++) win[i + 1] = history[i];
    for (i = 1; i < n; i++) begin
      v = win[i];
      j = i;
      while (j > 0 && win[j - 1] > v) begin
        win[j] = win[j - 1];
        j--;
      end
      win[j] = v;
    end
    if (n % 2 == 0) med_half = win[n / 2 - 1] + win[n / 2];
    else med_half = 2 * win[(n - 1) / 2];
    gap = 2 * sv - med_half;
    if (gap < 0) gap = -gap;
    r.bypassed = gap > 2 * int'(threshold_now);
    r.filtered_half = HALF_W'(r.bypassed ? 2 * sv : med_half);
    r.fill_count = CNT_W'(n);
    keep = (n >= WINDOW) ? WINDOW - 1 : n;
    for (i = keep - 1; i > 0; i--) history[i] = history[i - 1];
    history[0] = s;
    history_fill = keep;
    return r;
  endfunction

  // mostly a slow walk with small noise, plus spikes, repeats and wild values
  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int pick, off;
    pick = $urandom_range(99);
    if (pick < 4) begin
      walk_base = SAMPLE_W'($urandom);
      return walk_base;
    end else if (pick < 60) begin
      walk_base = SAMPLE_W'(int'(walk_base) + int'($urandom_range(6)) - 3);
      return SAMPLE_W'(int'(walk_base) + int'($urandom_range(40)) - 20);
    end else if (pick < 72) begin
      off = $urandom_range(40000, 100);
      if ($urandom_range(1)) off = -off;
      return SAMPLE_W'(int'(walk_base) + off);
    end else if (pick < 85) begin
      return SAMPLE_W'($urandom);
    end else if (pick < 92) begin
      case ($urandom_range(3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        default: return -16'sd1;
      endcase
    end
    return walk_base;
  endfunction

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[ADDR_W-1:2] == REG_THRESHOLD) threshold_now = data[THR_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[THR_W-1:0] !== threshold_now) begin
      $error("prdata: expected %0d, got %0d", threshold_now, prdata[THR_W-1:0]);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (samples_to_send.size() != 0 || in_valid || due_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] directed [$];
    directed = '{16'sd0, 16'sh8000, 16'sd32767, -16'sd1, 16'sd1, 16'sh8000,
                 16'sd32767, 16'sd16384, -16'sd16384, 16'sd21845, -16'sd21846,
                 16'sd2, -16'sd2, 16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd32767,
                 16'sh8000, 16'sd7, 16'sd8, -16'sd9, 16'sd12345, -16'sd12345};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          apb_write(THRESHOLD_ADDR, 32'd0);
          apb_write(UNUSED_ADDR, 32'h0000_1234);
        end
        2: apb_write(THRESHOLD_ADDR, 32'd65535);
        3: apb_write(THRESHOLD_ADDR, DATA_W'($urandom_range(60, 4)));
        4: apb_write(THRESHOLD_ADDR, DATA_W'($urandom_range(65535)));
        5: apb_write(THRESHOLD_ADDR, 32'd1);
        default: ;
      endcase
      apb_read_check(THRESHOLD_ADDR);
      if (ph < 2) begin
        send_idle = 22;
        recv_idle = 53;
      end else if (ph < 4) begin
        send_idle = 53;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (ph == 0) foreach (directed[k]) samples_to_send.push_back(directed[k]);
      repeat (ITEMS_PER_PHASE) samples_to_send.push_back(next_sample());
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (samples_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
        sample <= samples_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      due_results.push_back(predict_median(sample));
      in_taken = 1'b1;
    end
  end

  always @(posedge clk) begin
    filter_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected item: filtered_half %0d bypassed %0d fill_count %0d",
               filtered_half, bypassed, fill_count);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (filtered_half !== want.filtered_half) begin
          $error("filtered_half: expected %0d, got %0d", want.filtered_half, filtered_half);
          errors++;
        end
        if (bypassed !== want.bypassed) begin
          $error("bypassed: expected %0d, got %0d", want.bypassed, bypassed);
          errors++;
        end
        if (fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
